### hw/rtl/bcqs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcqs_pkg
// Shared types and codes of the bus command queue sequencer: the request and
// response items, the stored queue entry and the status, phase and action codes.
// ----------------------------------------------------------------------------
package bcqs_pkg;

   localparam logic [1:0] ACT_ENQUEUE  = 2'd0;
   localparam logic [1:0] ACT_POP      = 2'd1;
   localparam logic [1:0] ACT_TICK     = 2'd2;
   localparam logic [1:0] ACT_RESERVED = 2'd3;

   localparam logic [1:0] STS_EMPTY      = 2'd0;
   localparam logic [1:0] STS_PENDING    = 2'd1;
   localparam logic [1:0] STS_PROCESSING = 2'd2;
   localparam logic [1:0] STS_DONE       = 2'd3;

   localparam logic [1:0] PH_T1 = 2'd0;
   localparam logic [1:0] PH_T2 = 2'd1;
   localparam logic [1:0] PH_T3 = 2'd2;
   localparam logic [1:0] PH_T4 = 2'd3;

   localparam logic [2:0] BOP_CLOCK_ONLY = 3'd0;

   typedef struct packed {
      logic [1:0]  action;
      logic [1:0]  op_kind;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  bus_data;
      logic        wait_is_input;
      logic        wait_level;
      logic        wait_latch;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [1:0]  head_status;
      logic        head_data_valid;
      logic [7:0]  head_data;
      logic [2:0]  bus_op;
      logic [15:0] bus_address;
      logic [7:0]  bus_write_data;
      logic [1:0]  bus_t_state;
   } rsp_type;

   // One queue slot. The op_kind code has bit 0 set for write commands.
   typedef struct packed {
      logic [1:0]  op_kind;
      logic [15:0] address;
      logic [7:0]  write_byte;
      logic [7:0]  read_byte;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage
`default_nettype wire

### hw/rtl/bcqs_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcqs_req_if
// Request channel: valid/ready handshake carrying one command queue item.
// ----------------------------------------------------------------------------
interface bcqs_req_if;
   import bcqs_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/bcqs_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcqs_rsp_if
// Response channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface bcqs_rsp_if;
   import bcqs_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/bcqs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcqs_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read. The read data holds while no read is issued.
// ----------------------------------------------------------------------------
module bcqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### hw/rtl/bus_command_queue_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bus_command_queue_sequencer_top
// Ring queue of bus commands with a T-state sequencer for the head command.
//
//   channel    direction  handshake         item
//   req_chan   in         valid/ready       action and command or bus sample
//   rsp_chan   out        valid/ready       head report and bus cycle output
//
// Each item passes through ST_IDLE and ST_EXEC: the accept in ST_IDLE issues the
// read of the head slot from the entry RAM, and ST_EXEC finishes the item and
// loads the response register. The registered read of the entry RAM sets this split.
// Reset clears pointers and phase and sets head status pending; the RAM is not cleared.
// A stalled response holds the block in ST_EXEC; an item may still be accepted
// while an earlier response waits in the output register.
// ----------------------------------------------------------------------------
module bus_command_queue_sequencer_top #(
   parameter int QUEUE_DEPTH = 8
) (
   input wire logic   clock,
   input wire logic   reset,
   bcqs_req_if.sink   req_chan,
   bcqs_rsp_if.source rsp_chan
);
   import bcqs_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return i + 1'b1;
   endfunction

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [1:0]       hstat_ff, hstat_in;
   logic [1:0]       phase_ff, phase_in;
   logic             acc_ff, acc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   req_type          item_ff;
   rsp_type          rsp_ff, rsp_in;

   logic             req_fire;
   logic             exec_go;
   logic             full;
   logic             empty;
   logic             wait_hold;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_word;
   entry_type        rd_word;
   entry_type        word_new;
   logic             wb_en;
   logic [1:0]       t_status;
   logic [1:0]       out_status;
   logic             out_valid;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign exec_go        = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);
   assign full           = (next_idx(tail_ff) == head_ff);
   assign empty          = (head_ff == tail_ff);
   // T2 is stretched while the wait line is low and either sensed or driven.
   assign wait_hold      = !item_ff.wait_level && (item_ff.wait_is_input || item_ff.wait_latch);

   bcqs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (req_fire),
      .rd_addr (head_ff),
      .rd_data (rd_word)
   );

   // Tick on the head entry, using the slot fetched in the accept cycle; head report of every response.
   always_comb begin
      t_status = hstat_ff;
      phase_in = phase_ff;
      word_new = rd_word;
      wb_en    = 1'b0;
      rsp_in   = '0;
      if (state_ff == ST_IDLE) begin
         if (req_fire && req_chan.data.action == ACT_POP && !empty) begin
            phase_in = PH_T1;
         end
      end else if (item_ff.action == ACT_TICK) begin
         if (empty || hstat_ff == STS_DONE) begin
            phase_in = PH_T1;
         end else begin
            if (phase_ff == PH_T1) begin
               t_status = STS_PROCESSING;
            end
            rsp_in.bus_t_state = phase_ff;
            if (t_status == STS_PROCESSING) begin
               rsp_in.bus_op      = {1'b0, rd_word.op_kind} + 3'd1;
               rsp_in.bus_address = rd_word.address;
               if (!rd_word.op_kind[0]) begin
                  word_new.read_byte = item_ff.bus_data;
                  wb_en              = 1'b1;
               end else begin
                  rsp_in.bus_write_data = rd_word.write_byte;
               end
               case (phase_ff)
                  PH_T1: phase_in = PH_T2;
                  PH_T2: phase_in = wait_hold ? PH_T2 : PH_T3;
                  PH_T3: begin
                     t_status = STS_DONE;
                     phase_in = PH_T1;
                  end
                  default: phase_in = PH_T1;
               endcase
            end
         end
      end
      out_status             = empty ? STS_EMPTY : t_status;
      out_valid              = (out_status == STS_DONE) && !word_new.op_kind[0];
      rsp_in.accepted        = acc_ff;
      rsp_in.head_status     = out_status;
      rsp_in.head_data_valid = out_valid;
      rsp_in.head_data       = out_valid ? word_new.read_byte : 8'h00;
   end

   // Queue pointers, head status and the RAM write port.
   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      hstat_in = hstat_ff;
      acc_in   = acc_ff;
      wr_en    = 1'b0;
      wr_addr  = head_ff;
      wr_word  = word_new;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
               acc_in   = 1'b0;
               case (req_chan.data.action)
                  ACT_ENQUEUE: begin
                     if (!full) begin
                        wr_en              = 1'b1;
                        wr_addr            = tail_ff;
                        wr_word.op_kind    = req_chan.data.op_kind;
                        wr_word.address    = req_chan.data.address;
                        wr_word.write_byte = req_chan.data.write_data;
                        wr_word.read_byte  = 8'h00;
                        tail_in            = next_idx(tail_ff);
                        acc_in             = 1'b1;
                     end
                  end
                  ACT_POP: begin
                     // The next head has never been ticked, so it is pending.
                     if (!empty) begin
                        head_in  = next_idx(head_ff);
                        hstat_in = STS_PENDING;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
               if (item_ff.action == ACT_TICK && !empty) begin
                  hstat_in = t_status;
                  wr_en    = wb_en;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         hstat_ff     <= STS_PENDING;
         phase_ff     <= PH_T1;
         acc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         hstat_ff     <= hstat_in;
         phase_ff     <= (state_ff == ST_IDLE && !req_fire) ? phase_ff :
                         ((state_ff == ST_EXEC && !exec_go) ? phase_ff : phase_in);
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_chan.data;
      end
      if (exec_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

endmodule
`default_nettype wire
